@@ rtl/pdt_pkg.sv @@
`timescale 1ns / 1ps

package pdt_pkg;

    // Width of the wall-time, active-time and schedule counters.
    localparam int COUNT_WIDTH = 32;

    // Configuration registers are always 32 bits wide.
    localparam int REG_WIDTH = 32;

    // Working width for clamping and for the extend sum. It holds any
    // register value and any counter value, plus one carry bit.
    localparam int WIDE_W = ((COUNT_WIDTH > REG_WIDTH) ? COUNT_WIDTH : REG_WIDTH) + 1;

    localparam int CFG_INDEX_W = 2;

    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

    typedef logic [COUNT_WIDTH-1:0] t_count;
    typedef logic [REG_WIDTH-1:0]   t_reg;
    typedef logic [WIDE_W-1:0]      t_wide;

    typedef enum logic [2:0] {
        OP_TICK   = 3'd0,
        OP_START  = 3'd1,
        OP_STOP   = 3'd2,
        OP_PAUSE  = 3'd3,
        OP_RESUME = 3'd4,
        OP_EXTEND = 3'd5
    } t_op;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_INITIAL_DURATION = 2'd0,
        CFG_LIMIT_DURATION   = 2'd1
    } t_cfg_index;

    // Clamp a register value to the largest counter value.
    function automatic t_count clamp_cnt(input t_reg v);
        t_wide ext;
        ext = WIDE_W'(v);
        if (ext > WIDE_W'(CNT_MAX)) begin
            return CNT_MAX;
        end
        return ext[COUNT_WIDTH-1:0];
    endfunction

    // Increment that sticks at the largest counter value.
    function automatic t_count sat_inc(input t_count v);
        if (v == CNT_MAX) begin
            return v;
        end
        return v + COUNT_WIDTH'(1);
    endfunction

endpackage

@@ rtl/pausable_deadline_timer_top.sv @@
`timescale 1ns / 1ps

// A result word is registered and appears on the output in the cycle after its command word is accepted.
// Throughput: one command word per cycle while i_ready is high; the result register is the only stage.
// The input is ready whenever the result register is empty or is being taken in that cycle.
// Reset (i_rst_n low, synchronous) clears all timer flags, counters, the schedule and both
// configuration registers to zero, and empties the result register.
module pausable_deadline_timer_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,

    // Configuration write channel.
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [pdt_pkg::CFG_INDEX_W-1:0]   i_cfg_index,
    input  logic [31:0]                       i_cfg_data,

    // Command channel.
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [2:0]                        i_op,
    input  logic [31:0]                       i_amount,

    // Result channel.
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic                              o_accepted,
    output logic                              o_completed,
    output logic                              o_deadline_hit
);
    import pdt_pkg::*;

    // Configuration registers.
    t_reg   r_initial_duration;
    t_reg   r_limit_duration;

    // Timer state.
    logic   r_running;
    logic   r_paused;
    logic   r_completion_armed;
    logic   r_limit_armed;
    t_count r_wall_ticks;
    t_count r_active_ticks;
    t_count r_schedule;

    logic   n_running;
    logic   n_paused;
    logic   n_completion_armed;
    logic   n_limit_armed;
    t_count n_wall_ticks;
    t_count n_active_ticks;
    t_count n_schedule;

    // Result register.
    logic   r_out_valid;
    logic   r_accepted;
    logic   r_completed;
    logic   r_deadline_hit;

    logic   n_accepted;
    logic   n_completed;
    logic   n_deadline_hit;

    logic   in_fire;
    t_count lim;
    t_wide  ext_sum;
    t_count ext_sat;

    // The configuration port never stalls; the user must write only while idle; not enforced here.
    assign o_cfg_ready = 1'b1;

    // A new command can enter whenever the result register is free or draining.
    assign o_ready  = !r_out_valid || i_ready;
    assign in_fire  = i_valid && o_ready;

    assign o_valid         = r_out_valid;
    assign o_accepted      = r_accepted;
    assign o_completed     = r_completed;
    assign o_deadline_hit  = r_deadline_hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_initial_duration <= '0;
            r_limit_duration   <= '0;
        end else if (i_cfg_valid) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_INITIAL_DURATION: r_initial_duration <= i_cfg_data;
                CFG_LIMIT_DURATION:   r_limit_duration   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // The limit register is clamped to the counter range where it is used.
    assign lim = clamp_cnt(r_limit_duration);

    // Extend: saturating sum of schedule and amount, then held to the limit.
    assign ext_sum = WIDE_W'(r_schedule) + WIDE_W'(i_amount);

    always_comb begin
        if (ext_sum > WIDE_W'(CNT_MAX)) begin
            ext_sat = CNT_MAX;
        end else begin
            ext_sat = ext_sum[COUNT_WIDTH-1:0];
        end
        if (ext_sat > lim) begin
            ext_sat = lim;
        end
    end

    // Command decode and next state. A rejected command leaves the state alone.
    always_comb begin
        n_running          = r_running;
        n_paused           = r_paused;
        n_completion_armed = r_completion_armed;
        n_limit_armed      = r_limit_armed;
        n_wall_ticks       = r_wall_ticks;
        n_active_ticks     = r_active_ticks;
        n_schedule         = r_schedule;
        n_accepted         = 1'b0;
        n_completed        = 1'b0;
        n_deadline_hit     = 1'b0;

        case (t_op'(i_op))
            OP_TICK: begin
                n_accepted = 1'b1;
                if (r_running) begin
                    n_wall_ticks = sat_inc(r_wall_ticks);
                    // Completion is checked only on unpaused ticks, against the
                    // advanced active count, so a used-up schedule fires at once.
                    if (!r_paused) begin
                        n_active_ticks = sat_inc(r_active_ticks);
                        if (r_completion_armed && (n_active_ticks >= r_schedule)) begin
                            n_completed        = 1'b1;
                            n_completion_armed = 1'b0;
                        end
                    end
                    // The limit runs on wall time and ignores pause.
                    if (r_limit_armed && (n_wall_ticks >= lim)) begin
                        n_deadline_hit = 1'b1;
                        n_limit_armed  = 1'b0;
                    end
                end
            end
            OP_START: begin
                // A schedule above the limit cannot be started.
                if (!r_running && (r_initial_duration <= r_limit_duration)) begin
                    n_accepted         = 1'b1;
                    n_running          = 1'b1;
                    n_paused           = 1'b0;
                    n_completion_armed = 1'b1;
                    n_limit_armed      = 1'b1;
                    n_wall_ticks       = '0;
                    n_active_ticks     = '0;
                    n_schedule         = clamp_cnt(r_initial_duration);
                end
            end
            OP_STOP: begin
                // The counters keep their values until the next start.
                if (r_running) begin
                    n_accepted         = 1'b1;
                    n_running          = 1'b0;
                    n_paused           = 1'b0;
                    n_completion_armed = 1'b0;
                    n_limit_armed      = 1'b0;
                end
            end
            OP_PAUSE: begin
                if (r_running && !r_paused) begin
                    n_accepted = 1'b1;
                    n_paused   = 1'b1;
                end
            end
            OP_RESUME: begin
                if (r_running && r_paused) begin
                    n_accepted = 1'b1;
                    n_paused   = 1'b0;
                end
            end
            OP_EXTEND: begin
                if (r_running && (i_amount != '0)) begin
                    n_accepted         = 1'b1;
                    n_schedule         = ext_sat;
                    n_completion_armed = 1'b1;
                end
            end
            default: begin
                // Unused op codes are rejected and change nothing.
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_running          <= 1'b0;
            r_paused           <= 1'b0;
            r_completion_armed <= 1'b0;
            r_limit_armed      <= 1'b0;
            r_wall_ticks       <= '0;
            r_active_ticks     <= '0;
            r_schedule         <= '0;
        end else if (in_fire) begin
            r_running          <= n_running;
            r_paused           <= n_paused;
            r_completion_armed <= n_completion_armed;
            r_limit_armed      <= n_limit_armed;
            r_wall_ticks       <= n_wall_ticks;
            r_active_ticks     <= n_active_ticks;
            r_schedule         <= n_schedule;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_fire) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // The result word itself needs no reset; it is qualified by r_out_valid.
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_accepted     <= n_accepted;
            r_completed    <= n_completed;
            r_deadline_hit <= n_deadline_hit;
        end
    end

endmodule
